/* sv/ttg_pkg.sv */
package ttg_pkg;

    // block constants
    localparam int unsigned AUDIO_RATE_HZ = 48000;
    localparam int unsigned FRAME_CAP     = 48000;
    localparam int unsigned MS_PER_SEC    = 1000;
    localparam int unsigned FADE_DIV      = 5;
    localparam int unsigned PCM_MAX       = 32767;

    // field and datapath widths
    localparam int FREQ_W      = 16;
    localparam int DUR_W       = 10;
    localparam int AMP_W       = 15;
    localparam int CNT_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int DIVIDEND_W  = 32;
    localparam int DIVISOR_W   = 16;
    localparam int DIV_CNT_W   = 6;

    // frames from duration: rate = FRAMES_PER_MS * 1000 + FRAMES_REM, and the
    // remainder part duration * FRAMES_REM (below 2^20) is divided by 1000
    // through a reciprocal multiply
    localparam int unsigned FRAMES_PER_MS = AUDIO_RATE_HZ / MS_PER_SEC;
    localparam int unsigned FRAMES_REM    = AUDIO_RATE_HZ % MS_PER_SEC;
    localparam int          MS_REM_W      = 20;
    localparam int          MS_RCP_SH     = 30;
    localparam int          MS_RCP_W      = 21;
    localparam int          MS_PROD_W     = MS_REM_W + MS_RCP_W;
    localparam int unsigned MS_RCP        = ((32'd1 << MS_RCP_SH) + MS_PER_SEC - 1)
                                            / MS_PER_SEC;

    // one fifth of the frame count by reciprocal multiply
    localparam int          FIFTH_SH      = 19;
    localparam int          FIFTH_RCP_W   = 17;
    localparam int          FIFTH_PROD_W  = CNT_W + FIFTH_RCP_W;
    localparam int unsigned FIFTH_RCP     = ((32'd1 << FIFTH_SH) + FADE_DIV - 1) / FADE_DIV;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DUR  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_AMP  = CFG_IDX_W'(2);

    // register reset values
    localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(1200);
    localparam logic [DUR_W-1:0]  DUR_RST  = DUR_W'(30);
    localparam logic [AMP_W-1:0]  AMP_RST  = AMP_W'(8000);

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_FRAMES,
        OP_MUL_TRI,
        OP_MUL_FADE,
        OP_DIV,
        OP_WB_FRAMES,
        OP_WB_PERIOD,
        OP_WB_FIFTH,
        OP_WB_TRI,
        OP_WB_FADE,
        OP_EMIT,
        OP_DEACT
    } t_op;

    // divider operand selection
    typedef enum logic [1:0] {
        DS_PERIOD,
        DS_TRI,
        DS_FADE
    } t_dsel;

    typedef struct packed {
        t_op   op;
        t_dsel dsel;
    } t_cmd;

    typedef struct packed {
        logic tick_ok;
        logic fade_on;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

/* sv/ttg_div.sv */
module ttg_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ttg_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  logic [ttg_pkg::DIVISOR_W-1:0]     i_divisor,
    output logic                              o_done,
    output logic [ttg_pkg::DIVIDEND_W-1:0]    o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [ttg_pkg::DIV_CNT_W-1:0]    r_count;
    logic [ttg_pkg::DIVIDEND_W-1:0]   r_q;
    logic [ttg_pkg::DIVISOR_W-1:0]    r_rem;
    logic [ttg_pkg::DIVISOR_W-1:0]    r_divisor;

    logic [ttg_pkg::DIVISOR_W:0]      w_rem_sh;
    logic [ttg_pkg::DIVISOR_W:0]      w_rem_sub;
    logic                             w_fits;

    // one restoring step per cycle
    assign w_rem_sh  = {r_rem, r_q[ttg_pkg::DIVIDEND_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_divisor};
    assign w_fits    = (w_rem_sh >= {1'b0, r_divisor});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= ttg_pkg::DIV_CNT_W'(ttg_pkg::DIVIDEND_W);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == ttg_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q       <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[ttg_pkg::DIVIDEND_W-2:0], w_fits};
            r_rem <= w_fits ? w_rem_sub[ttg_pkg::DIVISOR_W-1:0]
                            : w_rem_sh[ttg_pkg::DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

/* sv/ttg_dpath.sv */
module ttg_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ttg_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  ttg_pkg::t_cmd                     i_cmd,
    output ttg_pkg::t_status                  o_status,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [ttg_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                              o_m_tlast
);

    // configuration
    logic [ttg_pkg::FREQ_W-1:0]   r_freq;
    logic [ttg_pkg::DUR_W-1:0]    r_dur;
    logic [ttg_pkg::AMP_W-1:0]    r_amp;

    // tone state
    logic [ttg_pkg::CNT_W-1:0]    r_index;
    logic [ttg_pkg::CNT_W-1:0]    r_phase;
    logic [ttg_pkg::CNT_W-1:0]    r_period;
    logic [ttg_pkg::CNT_W-1:0]    r_frames;
    logic [ttg_pkg::CNT_W-1:0]    r_fade_begin;
    logic                         r_active;

    // working registers
    logic [ttg_pkg::DIVIDEND_W-1:0] r_prod;
    logic                           r_neg;
    logic [ttg_pkg::AMP_W-1:0]      r_mag;
    logic                           r_out_valid;
    logic [ttg_pkg::SAMPLE_W-1:0]   r_out_sample;
    logic                           r_out_last;

    logic [ttg_pkg::CNT_W-2:0]      w_half;
    logic signed [18:0]             w_x;
    logic [18:0]                    w_x_abs;
    logic [ttg_pkg::DIVISOR_W-1:0]  w_mul_a;
    logic [ttg_pkg::DIVISOR_W-1:0]  w_mul_b;
    logic [ttg_pkg::DIVIDEND_W-1:0] w_mul_p;
    logic [ttg_pkg::MS_PROD_W-1:0]  w_ms_prod;
    logic [ttg_pkg::DIVIDEND_W-1:0] w_frames_raw;
    logic [ttg_pkg::FIFTH_PROD_W-1:0] w_fifth_prod;
    logic [ttg_pkg::CNT_W-1:0]      w_remaining;
    logic [ttg_pkg::CNT_W-1:0]      w_fade_len;
    logic [ttg_pkg::CNT_W:0]        w_phase_inc;
    logic                           w_last;
    logic [ttg_pkg::DIVIDEND_W-1:0] w_dividend;
    logic [ttg_pkg::DIVISOR_W-1:0]  w_divisor;
    logic                           w_div_done;
    logic [ttg_pkg::DIVIDEND_W-1:0] w_quot;

    // triangle offset from phase: rising then falling about zero
    assign w_half = r_period[ttg_pkg::CNT_W-1:1];
    always_comb begin
        if ({1'b0, r_phase} < {2'b00, w_half}) begin
            w_x = $signed({2'b00, r_phase, 1'b0}) - $signed({4'b0000, w_half});
        end else begin
            w_x = $signed({4'b0000, w_half}) + $signed({4'b0000, w_half})
                + $signed({4'b0000, w_half}) - $signed({2'b00, r_phase, 1'b0});
        end
        w_x_abs = w_x[18] ? 19'(-w_x) : 19'(w_x);
    end

    assign w_remaining = r_frames - r_index;
    assign w_fade_len  = r_frames - r_fade_begin;
    assign w_phase_inc = {1'b0, r_phase} + 1'b1;
    assign w_last      = ((r_index + 1'b1) == r_frames);

    // shared multiplier operands
    always_comb begin
        case (i_cmd.op)
            ttg_pkg::OP_MUL_FRAMES: begin
                w_mul_a = ttg_pkg::DIVISOR_W'(ttg_pkg::FRAMES_REM);
                w_mul_b = {6'b0, r_dur};
            end
            ttg_pkg::OP_MUL_TRI: begin
                w_mul_a = w_x_abs[ttg_pkg::DIVISOR_W-1:0];
                w_mul_b = {1'b0, r_amp};
            end
            default: begin
                w_mul_a = {1'b0, r_mag};
                w_mul_b = w_remaining;
            end
        endcase
    end
    assign w_mul_p = ttg_pkg::DIVIDEND_W'(w_mul_a) * ttg_pkg::DIVIDEND_W'(w_mul_b);

    // frame count: whole frames per ms plus the reciprocal-scaled remainder part
    assign w_ms_prod    = ttg_pkg::MS_PROD_W'(r_prod[ttg_pkg::MS_REM_W-1:0])
                        * ttg_pkg::MS_PROD_W'(ttg_pkg::MS_RCP);
    assign w_frames_raw = ttg_pkg::DIVIDEND_W'(r_dur) * ttg_pkg::DIVIDEND_W'(ttg_pkg::FRAMES_PER_MS)
                        + ttg_pkg::DIVIDEND_W'(w_ms_prod[ttg_pkg::MS_PROD_W-1:ttg_pkg::MS_RCP_SH]);

    // one fifth of the frame count
    assign w_fifth_prod = ttg_pkg::FIFTH_PROD_W'(r_frames)
                        * ttg_pkg::FIFTH_PROD_W'(ttg_pkg::FIFTH_RCP);

    // divider operands
    always_comb begin
        unique case (i_cmd.dsel)
            ttg_pkg::DS_PERIOD: begin
                w_dividend = ttg_pkg::DIVIDEND_W'(ttg_pkg::AUDIO_RATE_HZ);
                w_divisor  = (r_freq == '0) ? ttg_pkg::DIVISOR_W'(1) : r_freq;
            end
            ttg_pkg::DS_FADE: begin
                w_dividend = r_prod;
                w_divisor  = w_fade_len;
            end
            default: begin
                w_dividend = r_prod;
                w_divisor  = r_period;
            end
        endcase
    end

    ttg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == ttg_pkg::OP_DIV),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= ttg_pkg::FREQ_RST;
            r_dur  <= ttg_pkg::DUR_RST;
            r_amp  <= ttg_pkg::AMP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ttg_pkg::CFG_FREQ: r_freq <= i_cfg_wdata[ttg_pkg::FREQ_W-1:0];
                ttg_pkg::CFG_DUR:  r_dur  <= i_cfg_wdata[ttg_pkg::DUR_W-1:0];
                ttg_pkg::CFG_AMP:  r_amp  <= i_cfg_wdata[ttg_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // tone state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index      <= '0;
            r_phase      <= '0;
            r_period     <= ttg_pkg::CNT_W'(1);
            r_frames     <= '0;
            r_fade_begin <= '0;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == ttg_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                ttg_pkg::OP_WB_FRAMES: begin
                    if (w_frames_raw > ttg_pkg::DIVIDEND_W'(ttg_pkg::FRAME_CAP)) begin
                        r_frames <= ttg_pkg::CNT_W'(ttg_pkg::FRAME_CAP);
                    end else begin
                        r_frames <= w_frames_raw[ttg_pkg::CNT_W-1:0];
                    end
                end
                ttg_pkg::OP_WB_PERIOD: begin
                    if (w_quot[ttg_pkg::CNT_W-1:0] == '0) begin
                        r_period <= ttg_pkg::CNT_W'(1);
                    end else begin
                        r_period <= w_quot[ttg_pkg::CNT_W-1:0];
                    end
                end
                ttg_pkg::OP_WB_FIFTH: begin
                    r_fade_begin <= r_frames
                        - ttg_pkg::CNT_W'(w_fifth_prod[ttg_pkg::FIFTH_PROD_W-1:ttg_pkg::FIFTH_SH]);
                    r_index      <= '0;
                    r_phase      <= '0;
                    r_active     <= (r_frames != '0);
                end
                ttg_pkg::OP_DEACT: begin
                    r_active <= 1'b0;
                end
                ttg_pkg::OP_EMIT: begin
                    r_index     <= r_index + 1'b1;
                    r_phase     <= (w_phase_inc >= {1'b0, r_period}) ? '0
                                   : w_phase_inc[ttg_pkg::CNT_W-1:0];
                    r_active    <= r_active & ~w_last;
                end
                default: ;
            endcase
        end
    end

    // products, magnitude and output payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ttg_pkg::OP_MUL_FRAMES, ttg_pkg::OP_MUL_FADE: begin
                r_prod <= w_mul_p;
            end
            ttg_pkg::OP_MUL_TRI: begin
                r_prod <= {w_mul_p[ttg_pkg::DIVIDEND_W-2:0], 1'b0};
                r_neg  <= w_x[18];
            end
            ttg_pkg::OP_WB_TRI: begin
                if (w_quot > ttg_pkg::DIVIDEND_W'(ttg_pkg::PCM_MAX)) begin
                    r_mag <= ttg_pkg::AMP_W'(ttg_pkg::PCM_MAX);
                end else begin
                    r_mag <= w_quot[ttg_pkg::AMP_W-1:0];
                end
            end
            ttg_pkg::OP_WB_FADE: begin
                r_mag <= w_quot[ttg_pkg::AMP_W-1:0];
            end
            ttg_pkg::OP_EMIT: begin
                r_out_sample <= r_neg ? (ttg_pkg::SAMPLE_W'(0) - {1'b0, r_mag})
                                      : {1'b0, r_mag};
                r_out_last   <= w_last;
            end
            default: ;
        endcase
    end

    // status back to the controller
    assign o_status.tick_ok  = r_active && (r_index < r_frames);
    assign o_status.fade_on  = (r_index > r_fade_begin);
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = ~r_out_valid | i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sample;
    assign o_m_tlast  = r_out_last;

endmodule

/* sv/ttg_ctrl.sv */
module ttg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_start_req,
    input  ttg_pkg::t_status  i_status,
    output logic              o_in_ready,
    output ttg_pkg::t_cmd     o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b00000000001,
        ST_FR_RCP    = 11'b00000000010,
        ST_PER_DIV   = 11'b00000000100,
        ST_PER_WAIT  = 11'b00000001000,
        ST_FIF_RCP   = 11'b00000010000,
        ST_TRI_DIV   = 11'b00000100000,
        ST_TRI_WAIT  = 11'b00001000000,
        ST_FADE_MUL  = 11'b00010000000,
        ST_FADE_DIV  = 11'b00100000000,
        ST_FADE_WAIT = 11'b01000000000,
        ST_EMIT      = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and datapath command
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = ttg_pkg::OP_NONE;
        o_cmd.dsel = ttg_pkg::DS_TRI;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_start_req) begin
                        o_cmd.op = ttg_pkg::OP_MUL_FRAMES;
                        n_state  = ST_FR_RCP;
                    end else if (i_status.tick_ok) begin
                        o_cmd.op = ttg_pkg::OP_MUL_TRI;
                        n_state  = ST_TRI_DIV;
                    end else begin
                        o_cmd.op = ttg_pkg::OP_DEACT;
                    end
                end
            end
            ST_FR_RCP: begin
                o_cmd.op = ttg_pkg::OP_WB_FRAMES;
                n_state  = ST_PER_DIV;
            end
            ST_PER_DIV: begin
                o_cmd.op   = ttg_pkg::OP_DIV;
                o_cmd.dsel = ttg_pkg::DS_PERIOD;
                n_state    = ST_PER_WAIT;
            end
            ST_PER_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = ttg_pkg::OP_WB_PERIOD;
                    n_state  = ST_FIF_RCP;
                end
            end
            ST_FIF_RCP: begin
                o_cmd.op = ttg_pkg::OP_WB_FIFTH;
                n_state  = ST_IDLE;
            end
            ST_TRI_DIV: begin
                o_cmd.op   = ttg_pkg::OP_DIV;
                o_cmd.dsel = ttg_pkg::DS_TRI;
                n_state    = ST_TRI_WAIT;
            end
            ST_TRI_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = ttg_pkg::OP_WB_TRI;
                    n_state  = i_status.fade_on ? ST_FADE_MUL : ST_EMIT;
                end
            end
            ST_FADE_MUL: begin
                o_cmd.op = ttg_pkg::OP_MUL_FADE;
                n_state  = ST_FADE_DIV;
            end
            ST_FADE_DIV: begin
                o_cmd.op   = ttg_pkg::OP_DIV;
                o_cmd.dsel = ttg_pkg::DS_FADE;
                n_state    = ST_FADE_WAIT;
            end
            ST_FADE_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = ttg_pkg::OP_WB_FADE;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold the sample until the output register is free
                if (i_status.out_free) begin
                    o_cmd.op = ttg_pkg::OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/triangle_tone_generator_fade_top.sv */
// Triangle-wave tone generator with a linear fade-out over the last fifth of the tone.
// An input transaction with start_req set (s_axis_tdata bit 0) loads a new tone from the
// frequency, duration and amplitude registers and produces no output; each later transaction
// with start_req clear produces one signed 16-bit sample on m_axis_tdata until the tone
// length is reached, with m_axis_tlast on the final one; ticks while idle produce nothing.
// The period, triangle and fade divisions share one divider that retires one quotient bit
// per clock, and the divisions by 1000 and by 5 use reciprocal multiplication. After an
// accepted start or tick the input is held off until the block is back in idle, also while
// a sample waits for m_axis_tready; an idle tick does not hold it off. Frequency, duration
// and the fade point are latched at start, the amplitude is read for every sample.
module triangle_tone_generator_fade_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ttg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ttg_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [0] start_req, [7:1] zero
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ttg_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [15:0] sample
    output logic                             m_axis_tlast
);

    ttg_pkg::t_cmd    w_cmd;
    ttg_pkg::t_status w_status;

    ttg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_start_req (s_axis_tdata[0]),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    ttg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

/* dv/tb_triangle_tone_generator_fade_top.sv */
`timescale 1ns / 1ps

module tb_triangle_tone_generator_fade_top;

    localparam int          ITEM_TARGET = 950;
    localparam int          GAP_MAX     = 13;
    localparam int          SETTLE      = 200;
    localparam int          HOLD_CYCLES = 600;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // register index that maps to nothing
    localparam logic [ttg_pkg::CFG_IDX_W-1:0] CFG_SPARE = ttg_pkg::CFG_IDX_W'(3);

    typedef struct packed {
        logic [ttg_pkg::SAMPLE_W-1:0] sample;
        logic                         last;
    } t_tone_sample;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [ttg_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [ttg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [ttg_pkg::S_TDATA_W-1:0]    s_axis_tdata;   // [0] start_req, [7:1] zero
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [ttg_pkg::M_TDATA_W-1:0]    m_axis_tdata;   // [15:0] sample
    logic                             m_axis_tlast;

    triangle_tone_generator_fade_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // pending start/tick requests and expected samples
    bit           req_queue[$];
    t_tone_sample sample_expect[$];

    int          items_queued   = 0;
    int          items_accepted = 0;
    int          err_count      = 0;
    int unsigned cycle_count    = 0;

    int in_idle_max  = 0;
    int out_idle_max = 0;
    int in_gap       = 0;
    int out_gap      = 0;
    bit in_fire      = 1'b0;
    bit out_fire     = 1'b0;
    bit rx_hold      = 1'b0;

    // predictor copy of registers and tone state
    logic [ttg_pkg::FREQ_W-1:0] p_freq;
    logic [ttg_pkg::DUR_W-1:0]  p_dur;
    logic [ttg_pkg::AMP_W-1:0]  p_amp;
    int unsigned                t_index, t_phase, t_period, t_frames, t_fade;
    bit                         t_active;

    // stimulus-side shadow of the duration, used to size tick runs
    int unsigned       sh_dur;

    task automatic tone_predict(input logic start_req);
        longint frames;
        longint half;
        longint ph;
        longint x;
        longint s;
        bit     is_last;
        if (start_req) begin
            frames = longint'(ttg_pkg::AUDIO_RATE_HZ) * longint'(p_dur)
                   / longint'(ttg_pkg::MS_PER_SEC);
            if (frames > longint'(ttg_pkg::FRAME_CAP))
                frames = longint'(ttg_pkg::FRAME_CAP);
            t_frames = frames[ttg_pkg::CNT_W-1:0];
            t_period = ttg_pkg::AUDIO_RATE_HZ / ((p_freq == '0) ? 1 : int'(p_freq));
            if (t_period < 1)
                t_period = 1;
            t_period = t_period & 32'hFFFF;
            if (t_period == 0)
                t_period = 1;
            t_fade   = t_frames - t_frames / ttg_pkg::FADE_DIV;
            t_index  = 0;
            t_phase  = 0;
            t_active = (t_frames > 0);
        end else if (!t_active || t_index >= t_frames) begin
            t_active = 1'b0;
        end else begin
            // triangle from the phase within the period
            half = longint'(t_period / 2);
            ph   = longint'(t_phase % t_period);
            if (ph < half)
                x = ph * 2 - half;
            else
                x = half - (ph - half) * 2;
            s = (x * longint'(p_amp) * 2) / longint'(t_period);
            if (s > longint'(ttg_pkg::PCM_MAX))
                s = longint'(ttg_pkg::PCM_MAX);
            if (s < -longint'(ttg_pkg::PCM_MAX))
                s = -longint'(ttg_pkg::PCM_MAX);
            is_last = ((t_index + 1) == t_frames);
            // linear fade past the fade point
            if (t_index > t_fade)
                s = (s * longint'(t_frames - t_index)) / longint'(t_frames - t_fade);
            sample_expect.push_back('{sample: s[ttg_pkg::SAMPLE_W-1:0], last: is_last});
            t_index = t_index + 1;
            ph      = ph + 1;
            if (ph >= longint'(t_period))
                ph = 0;
            t_phase = int'(ph);
            if (is_last)
                t_active = 1'b0;
        end
    endtask

    // sampling: register writes, input transactions, output checks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            p_freq   = ttg_pkg::FREQ_RST;
            p_dur    = ttg_pkg::DUR_RST;
            p_amp    = ttg_pkg::AMP_RST;
            t_index  = 0;
            t_phase  = 0;
            t_period = 1;
            t_frames = 0;
            t_fade   = 0;
            t_active = 1'b0;
            in_fire  = 1'b0;
            out_fire = 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    ttg_pkg::CFG_FREQ: p_freq = i_cfg_wdata[ttg_pkg::FREQ_W-1:0];
                    ttg_pkg::CFG_DUR:  p_dur  = i_cfg_wdata[ttg_pkg::DUR_W-1:0];
                    ttg_pkg::CFG_AMP:  p_amp  = i_cfg_wdata[ttg_pkg::AMP_W-1:0];
                    default: ;
                endcase
            end
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire) begin
                tone_predict(s_axis_tdata[0]);
                items_accepted++;
            end
            out_fire = m_axis_tvalid && m_axis_tready;
            if (out_fire) begin
                if (sample_expect.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected sample %0d last %0b",
                                 $signed(m_axis_tdata), m_axis_tlast);
                end else begin
                    t_tone_sample exp_s;
                    exp_s = sample_expect.pop_front();
                    if (m_axis_tdata !== exp_s.sample || m_axis_tlast !== exp_s.last) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("sample mismatch: expected %0d last %0b, got %0d last %0b",
                                     $signed(exp_s.sample), exp_s.last,
                                     $signed(m_axis_tdata), m_axis_tlast);
                    end
                end
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_fire) begin
            // transaction still waiting for ready
        end else if (in_gap != 0) begin
            s_axis_tvalid <= 1'b0;
            in_gap--;
        end else if (req_queue.size() != 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(ttg_pkg::S_TDATA_W-1){1'b0}}, req_queue.pop_front()};
            in_gap        = $urandom_range(0, in_idle_max);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // output receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_fire)
                out_gap = $urandom_range(0, out_idle_max);
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (out_gap != 0) begin
                m_axis_tready <= 1'b0;
                out_gap--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver stall while the sender keeps offering ticks
    initial begin
        do @(posedge i_clk);
        while (!(items_accepted >= 300 && req_queue.size() >= 20));
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_req(input bit start_req);
        req_queue.push_back(start_req);
        items_queued++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_req(1'b0);
    endtask

    // wait for all transactions and samples, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_accepted != items_queued || sample_expect.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // one register write; caller lowers the enable after a batch
    task automatic cfg_write(input logic [ttg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ttg_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        if (idx == ttg_pkg::CFG_DUR)
            sh_dur = data[ttg_pkg::DUR_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [ttg_pkg::FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ttg_pkg::FREQ_W'(1);
            2:       return ttg_pkg::FREQ_W'(ttg_pkg::AUDIO_RATE_HZ);
            3:       return ttg_pkg::FREQ_W'(ttg_pkg::AUDIO_RATE_HZ + 1);
            4:       return '1;
            7:       return ttg_pkg::FREQ_W'($urandom);
            default: return ttg_pkg::FREQ_W'($urandom_range(100, 4000));
        endcase
    endfunction

    function automatic logic [ttg_pkg::AMP_W-1:0] pick_amp();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return ttg_pkg::AMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [ttg_pkg::DUR_W-1:0] pick_dur();
        case ($urandom_range(0, 9))
            6:       return ttg_pkg::DUR_W'(2);
            7:       return '0;
            8:       return ttg_pkg::DUR_W'(1000);
            9:       return ttg_pkg::DUR_W'($urandom);
            default: return ttg_pkg::DUR_W'(1);
        endcase
    endfunction

    // stimulus
    initial begin
        int unsigned frames;
        int          n;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        sh_dur        = ttg_pkg::DUR_RST;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: tick while idle, then a default tone
        push_req(1'b0);
        push_req(1'b1);
        push_ticks(3);
        wait_drained();

        // amplitude change mid-tone, frequency change waits for next start
        cfg_write(ttg_pkg::CFG_AMP, ttg_pkg::CFG_DATA_W'(ttg_pkg::PCM_MAX));
        cfg_done();
        push_ticks(2);
        wait_drained();
        cfg_write(ttg_pkg::CFG_FREQ, '1);
        cfg_done();
        push_ticks(1);
        wait_drained();

        // frequency above sample rate gives silence; restart during the tone
        push_req(1'b1);
        push_ticks(2);
        push_req(1'b1);
        push_ticks(1);
        wait_drained();

        // zero frequency, zero-length tone, write to the spare index
        cfg_write(ttg_pkg::CFG_FREQ, '0);
        cfg_write(ttg_pkg::CFG_DUR, '0);
        cfg_write(CFG_SPARE, ttg_pkg::CFG_DATA_W'($urandom));
        cfg_done();
        push_req(1'b1);
        push_ticks(2);
        wait_drained();

        // longest duration hits the frame cap, zero amplitude
        cfg_write(ttg_pkg::CFG_DUR, ttg_pkg::CFG_DATA_W'(16'hFFFF));
        cfg_write(ttg_pkg::CFG_AMP, '0);
        cfg_done();
        push_req(1'b1);
        push_ticks(2);
        wait_drained();

        // random tones
        while (items_queued < ITEM_TARGET) begin
            in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, GAP_MAX);
            out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, GAP_MAX);
            case ($urandom_range(0, 9))
                0: begin
                    // noise: stray starts and ticks
                    n = $urandom_range(1, 6);
                    repeat (n) push_req($urandom_range(0, 1));
                end
                1: begin
                    // amplitude change while a tone may be running
                    cfg_write(ttg_pkg::CFG_AMP, {1'($urandom), pick_amp()});
                    cfg_done();
                    push_ticks($urandom_range(1, 20));
                end
                default: begin
                    cfg_write(ttg_pkg::CFG_DUR, {6'($urandom), pick_dur()});
                    if ($urandom_range(0, 1))
                        cfg_write(ttg_pkg::CFG_FREQ, pick_freq());
                    if ($urandom_range(0, 1))
                        cfg_write(ttg_pkg::CFG_AMP, {1'($urandom), pick_amp()});
                    if ($urandom_range(0, 7) == 0)
                        cfg_write(CFG_SPARE, ttg_pkg::CFG_DATA_W'($urandom));
                    cfg_done();
                    frames = ttg_pkg::AUDIO_RATE_HZ * sh_dur / ttg_pkg::MS_PER_SEC;
                    if (frames > ttg_pkg::FRAME_CAP)
                        frames = ttg_pkg::FRAME_CAP;
                    if (frames > 96)
                        n = $urandom_range(1, 40);
                    else if (frames != 0 && $urandom_range(0, 3) == 0)
                        n = $urandom_range(1, frames);
                    else
                        n = frames + $urandom_range(0, 2);
                    push_req(1'b1);
                    push_ticks(n);
                end
            endcase
            wait_drained();
        end

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
sv/ttg_pkg.sv
sv/ttg_div.sv
sv/ttg_dpath.sv
sv/ttg_ctrl.sv
sv/triangle_tone_generator_fade_top.sv
dv/tb_triangle_tone_generator_fade_top.sv
